// ===== rtl/ema_light_dip_counter_assert.svh =====
// Assertion macros used by the light dip counter RTL.
// Each macro checks on the rising clock edge and is disabled while reset is held.
`ifndef EMA_LIGHT_DIP_COUNTER_ASSERT_SVH
`define EMA_LIGHT_DIP_COUNTER_ASSERT_SVH

// The expression holds at every edge.
`define EMADIP_ASSERT_HOLDS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error(msg);

// When the condition holds, the property holds in the same cycle.
`define EMADIP_ASSERT_IMPLIES(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// When the condition holds, the property holds in the next cycle.
`define EMADIP_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/emadip_pkg.sv =====
`default_nettype none

package emadip_pkg;

    // Configuration register layout.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int WEIGHT_BITS    = 16;
    localparam int OFFSET_BITS    = 12;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_AVERAGE_WEIGHT  = 2'd0,
        CFG_DIP_THRESHOLD   = 2'd1,
        CFG_RECOVERY_OFFSET = 2'd2
    } cfg_index_t;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET    = 16'd66;
    localparam logic [OFFSET_BITS-1:0] THRESHOLD_RESET = 12'd228;
    localparam logic [OFFSET_BITS-1:0] RECOVERY_RESET  = 12'd68;

    // Request kinds on the input stream.
    typedef enum logic {
        OP_SAMPLE       = 1'b0,
        OP_INTERVAL_END = 1'b1
    } op_t;

    // Counter widths and their saturation values.
    localparam int COUNT_BITS = 16;
    localparam int TOTAL_BITS = 48;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

endpackage

`default_nettype wire

// ===== rtl/ema_light_dip_counter.sv =====
// A request accepted into the input register shows its result on m_tvalid from the output
// register; the average update and dip tests form one registered pass between the two.
// Throughput: one request per cycle without stalls; the average multiply feedback sets it.
// A stalled result holds in the output register while one more request is buffered.
// Reset (aresetn low, synchronous) clears the average, dip state and all counters and
// restores the configuration registers to their defaults. No clearing pass is needed.
`default_nettype none

`include "ema_light_dip_counter_assert.svh"

module ema_light_dip_counter #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // Configuration write channel.
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [emadip_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [emadip_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    // Input stream.
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // Fields from bit 0: sample, zero padding to a whole byte.
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
    // Fields from bit 0: op.
    input  wire logic [0:0]                              s_tuser,

    // Result stream.
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // Fields from bit 0: average_code, dip_count, interval_samples, total_samples,
    // in_dip, zero padding to a whole byte.
    output logic [((SAMPLE_BITS+2*emadip_pkg::COUNT_BITS+emadip_pkg::TOTAL_BITS+1+7)/8)*8-1:0]
                                                         m_tdata
);

    localparam int AW  = SAMPLE_BITS + FRAC_BITS;
    localparam int OB  = emadip_pkg::OFFSET_BITS;
    localparam int CB  = emadip_pkg::COUNT_BITS;
    localparam int TB  = emadip_pkg::TOTAL_BITS;
    localparam int WB  = emadip_pkg::WEIGHT_BITS;
    localparam int TW  = ((SAMPLE_BITS > OB) ? SAMPLE_BITS : OB) + FRAC_BITS + 1;
    localparam int OUT_BITS = SAMPLE_BITS + 2*CB + TB + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Configuration registers.
    logic [WB-1:0] weight_reg;
    logic [OB-1:0] threshold_reg;
    logic [OB-1:0] recovery_reg;

    // Input register.
    logic                   in_valid_reg;
    emadip_pkg::op_t        in_op_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // Block state.
    logic [AW-1:0] average_reg,   average_next;
    logic          first_reg,     first_next;
    logic          dip_reg,       dip_next;
    logic [CB-1:0] dip_cnt_reg,   dip_cnt_next;
    logic [CB-1:0] int_cnt_reg,   int_cnt_next;
    logic [TB-1:0] total_cnt_reg, total_cnt_next;

    // Output register.
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    logic          advance;
    logic          fire;
    logic          s_accept;
    logic [AW-1:0] average_calc;
    logic [AW-1:0] fx;
    logic [TW-1:0] trig_level;
    logic [TW-1:0] reco_level;
    logic [TW-1:0] average_ext;
    logic [CB-1:0] dip_cnt_rep;
    logic [CB-1:0] int_cnt_rep;
    logic [TB-1:0] total_cnt_rep;
    logic          dip_rep;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg    <= emadip_pkg::WEIGHT_RESET;
            threshold_reg <= emadip_pkg::THRESHOLD_RESET;
            recovery_reg  <= emadip_pkg::RECOVERY_RESET;
        end else if (cfg_valid) begin
            case (emadip_pkg::cfg_index_t'(cfg_index))
                emadip_pkg::CFG_AVERAGE_WEIGHT:  weight_reg    <= cfg_data[WB-1:0];
                emadip_pkg::CFG_DIP_THRESHOLD:   threshold_reg <= cfg_data[OB-1:0];
                emadip_pkg::CFG_RECOVERY_OFFSET: recovery_reg  <= cfg_data[OB-1:0];
                default: ;
            endcase
        end
    end

    // Input register holds one request ahead of the update pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg     <= emadip_pkg::op_t'(s_tuser[0]);
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
    end

    emadip_avg #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_avg (
        .average       (average_reg),
        .sample        (in_sample_reg),
        .weight        (weight_reg),
        .first_pending (first_reg),
        .average_next  (average_calc)
    );

    // Dip levels, compared against the freshly updated average.
    always_comb begin
        fx          = {in_sample_reg, {FRAC_BITS{1'b0}}};
        trig_level  = {{(TW-AW){1'b0}}, fx}
                    + {{(TW-OB-FRAC_BITS){1'b0}}, threshold_reg, {FRAC_BITS{1'b0}}};
        reco_level  = {{(TW-AW){1'b0}}, fx}
                    + {{(TW-OB-FRAC_BITS){1'b0}}, recovery_reg, {FRAC_BITS{1'b0}}};
        average_ext = {{(TW-AW){1'b0}}, average_calc};
    end

    // Next state and the values reported for this request.
    always_comb begin
        average_next  = average_reg;
        first_next    = first_reg;
        dip_rep       = dip_reg;
        dip_cnt_rep   = dip_cnt_reg;
        int_cnt_rep   = int_cnt_reg;
        total_cnt_rep = total_cnt_reg;
        if (in_op_reg == emadip_pkg::OP_SAMPLE) begin
            average_next = average_calc;
            first_next   = 1'b0;
            if (int_cnt_reg != emadip_pkg::COUNT_MAX) begin
                int_cnt_rep = int_cnt_reg + 1'b1;
            end
            if (total_cnt_reg != emadip_pkg::TOTAL_MAX) begin
                total_cnt_rep = total_cnt_reg + 1'b1;
            end
            // The start test takes priority over the end test.
            priority if (trig_level <= average_ext) begin
                if (!dip_reg) begin
                    dip_rep = 1'b1;
                    if (dip_cnt_reg != emadip_pkg::COUNT_MAX) begin
                        dip_cnt_rep = dip_cnt_reg + 1'b1;
                    end
                end
            end else if (reco_level >= average_ext) begin
                dip_rep = 1'b0;
            end else begin
                // Between the two levels the dip state holds.
                dip_rep = dip_reg;
            end
        end
        dip_next       = dip_rep;
        total_cnt_next = total_cnt_rep;
        if (in_op_reg == emadip_pkg::OP_INTERVAL_END) begin
            dip_cnt_next = '0;
            int_cnt_next = '0;
        end else begin
            dip_cnt_next = dip_cnt_rep;
            int_cnt_next = int_cnt_rep;
        end
    end

    // State update on each request that passes to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            average_reg   <= '0;
            first_reg     <= 1'b1;
            dip_reg       <= 1'b0;
            dip_cnt_reg   <= '0;
            int_cnt_reg   <= '0;
            total_cnt_reg <= '0;
        end else if (fire) begin
            average_reg   <= average_next;
            first_reg     <= first_next;
            dip_reg       <= dip_next;
            dip_cnt_reg   <= dip_cnt_next;
            int_cnt_reg   <= int_cnt_next;
            total_cnt_reg <= total_cnt_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= {{(OUT_W-OUT_BITS){1'b0}}, dip_rep, total_cnt_rep, int_cnt_rep,
                           dip_cnt_rep, average_next[AW-1:FRAC_BITS]};
        end
    end

    // Every started dip needs a sample in the same interval.
    `EMADIP_ASSERT_HOLDS(a_dip_le_interval, aclk, aresetn, dip_cnt_reg <= int_cnt_reg,
        "dip count exceeds interval sample count")
    // Interval samples are a subset of all samples.
    `EMADIP_ASSERT_HOLDS(a_interval_le_total, aclk, aresetn,
        ({{(TB-CB){1'b0}}, int_cnt_reg} <= total_cnt_reg),
        "interval sample count exceeds total sample count")
    // After a sample passes, the first-sample load is no longer pending.
    `EMADIP_ASSERT_NEXT(a_first_cleared, aclk, aresetn,
        fire && (in_op_reg == emadip_pkg::OP_SAMPLE), !first_reg && (total_cnt_reg != '0),
        "sample did not clear first-pending or count")
    // A buffered request that cannot advance stays buffered.
    `EMADIP_ASSERT_NEXT(a_input_held, aclk, aresetn, in_valid_reg && !advance, in_valid_reg,
        "buffered request lost under backpressure")
    // A request that passes always leaves a result waiting.
    `EMADIP_ASSERT_NEXT(a_result_made, aclk, aresetn, fire, m_valid_reg,
        "update pass produced no result")

endmodule

`default_nettype wire

// ===== rtl/emadip_avg.sv =====
`default_nettype none

module emadip_avg #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic [SAMPLE_BITS+FRAC_BITS-1:0]  average,
    input  wire logic [SAMPLE_BITS-1:0]            sample,
    input  wire logic [emadip_pkg::WEIGHT_BITS-1:0] weight,
    input  wire logic                              first_pending,
    output logic      [SAMPLE_BITS+FRAC_BITS-1:0]  average_next
);

    localparam int AW = SAMPLE_BITS + FRAC_BITS;
    localparam int WB = emadip_pkg::WEIGHT_BITS;
    localparam int PW = AW + WB + 2;
    localparam logic [PW-1:0] ROUND_HALF = {{(PW-WB){1'b0}}, 1'b1, {(WB-1){1'b0}}};

    logic        [AW-1:0] fx;
    logic signed [AW:0]   diff;
    logic signed [PW-1:0] diff_ext;
    logic signed [PW-1:0] weight_ext;
    logic signed [PW-1:0] product;
    logic signed [PW-1:0] rounded;
    logic signed [PW-1:0] step;

    // The blend avg*(1-w) + fx*w is rewritten as avg + (fx - avg)*w, so a single
    // signed multiply does the work. The arithmetic shift floors, which matches
    // rounding half up of the full sum since avg*65536 is exact.
    always_comb begin
        fx         = {sample, {FRAC_BITS{1'b0}}};
        diff       = $signed({1'b0, fx}) - $signed({1'b0, average});
        diff_ext   = {{(WB+1){diff[AW]}}, diff};
        weight_ext = {{(AW+2){1'b0}}, weight};
        product    = diff_ext * weight_ext;
        rounded    = product + $signed(ROUND_HALF);
        step       = rounded >>> WB;
        if (first_pending) begin
            average_next = fx;
        end else begin
            average_next = average + step[AW-1:0];
        end
    end

endmodule

`default_nettype wire
